// ===== sv/lc3x_pkg.sv =====
// Package: shared types, codes and constants of the LC-3 instruction executor.
package lc3x_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int PUTS_LIMIT = 64;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int CNT_W      = $clog2(PUTS_LIMIT + 1);

  localparam logic [15:0] PSR_INIT = 16'h4000;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // register write targets beyond the general registers
  localparam logic [3:0] REG_PC  = 4'd8;
  localparam logic [3:0] REG_PSR = 4'd9;

  // opcodes
  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LD   = 4'h2;
  localparam logic [3:0] OPC_ST   = 4'h3;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDR  = 4'h6;
  localparam logic [3:0] OPC_STR  = 4'h7;
  localparam logic [3:0] OPC_RTI  = 4'h8;
  localparam logic [3:0] OPC_NOT  = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_STI  = 4'hB;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_RSV  = 4'hD;
  localparam logic [3:0] OPC_LEA  = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  // trap vectors
  localparam logic [7:0] TRAP_GETC  = 8'h20;
  localparam logic [7:0] TRAP_OUT   = 8'h21;
  localparam logic [7:0] TRAP_PUTS  = 8'h22;
  localparam logic [7:0] TRAP_IN    = 8'h23;
  localparam logic [7:0] TRAP_PUTSP = 8'h24;
  localparam logic [7:0] TRAP_HALT  = 8'h25;

  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_MWR  = 2'd1,
    OP_MRD  = 2'd2,
    OP_RWR  = 2'd3
  } host_op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  reg_index;
    logic [7:0]  key_char;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        pc;
    logic [15:0]        read_data;
    logic [2:0]         cond_codes;
    logic               char_valid;
    logic [7:0]         out_char;
    logic signed [15:0] call_depth;
    logic               last;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MRD, S_DECODE, S_OPA, S_EXEC,
    S_MEMA, S_MEMB, S_MEMC, S_PUTS, S_PEND, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MA_IN, MA_PC, MA_EA, MA_RDATA, MA_A, MA_PTRN, MA_CLR
  } mem_sel_t;

  typedef enum logic [1:0] {
    WD_IN, WD_B, WD_ZERO
  } wd_sel_t;

  typedef enum logic [1:0] {
    CH_NONE, CH_A, CH_HELD
  } char_sel_t;

  typedef struct packed {
    mem_sel_t   mem_sel;
    logic       mem_we;
    wd_sel_t    wd_sel;
    logic       host_wr;
    logic       latch_key;
    logic       load_ir;
    logic       load_a;
    logic       exec;
    logic       load_wb;
    logic       puts_start;
    logic       puts_step;
    logic       clr_step;
    logic       emit;
    logic [1:0] emit_status;
    char_sel_t  emit_char;
    logic       emit_rd;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic       halted;
    logic       legal;
    logic [3:0] opc;
    logic [7:0] vec;
    logic       word_zero;
    logic       cnt_zero;
    logic       cnt_full;
    logic       clr_done;
  } stat_t;

endpackage

// ===== sv/lc3x_ram.sv =====
// Generic RAM: one write port, one read port, registered read data.
module lc3x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lc3x_ctrl.sv =====
// Controller: sequences clear, host accesses and instruction phases.
module lc3x_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      op,
  input  lc3x_pkg::stat_t stat,
  output logic            busy,
  output lc3x_pkg::cmd_t  cmd
);

  lc3x_pkg::state_t      state_r, state_nxt;
  logic [1:0]            done_st_r, done_st_nxt;
  lc3x_pkg::char_sel_t   done_ch_r, done_ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lc3x_pkg::S_CLEAR;
      done_st_r <= lc3x_pkg::ST_OK;
      done_ch_r <= lc3x_pkg::CH_NONE;
    end else begin
      state_r   <= state_nxt;
      done_st_r <= done_st_nxt;
      done_ch_r <= done_ch_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    done_st_nxt = done_st_r;
    done_ch_nxt = done_ch_r;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state_r)
      lc3x_pkg::S_CLEAR: begin
        cmd.mem_sel  = lc3x_pkg::MA_CLR;
        cmd.mem_we   = 1'b1;
        cmd.wd_sel   = lc3x_pkg::WD_ZERO;
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = lc3x_pkg::S_IDLE;
      end
      lc3x_pkg::S_IDLE: begin
        busy        = 1'b0;
        done_st_nxt = lc3x_pkg::ST_OK;
        done_ch_nxt = lc3x_pkg::CH_NONE;
        if (start) begin
          cmd.latch_key = 1'b1;
          unique case (lc3x_pkg::host_op_t'(op))
            lc3x_pkg::OP_MWR: begin
              cmd.mem_sel = lc3x_pkg::MA_IN;
              cmd.mem_we  = 1'b1;
              cmd.wd_sel  = lc3x_pkg::WD_IN;
              state_nxt   = lc3x_pkg::S_DONE;
            end
            lc3x_pkg::OP_MRD: begin
              cmd.mem_sel = lc3x_pkg::MA_IN;
              state_nxt   = lc3x_pkg::S_MRD;
            end
            lc3x_pkg::OP_RWR: begin
              cmd.host_wr = 1'b1;
              state_nxt   = lc3x_pkg::S_DONE;
            end
            default: begin
              if (stat.halted) begin
                done_st_nxt = lc3x_pkg::ST_HALT;
                state_nxt   = lc3x_pkg::S_DONE;
              end else begin
                cmd.mem_sel = lc3x_pkg::MA_PC;
                state_nxt   = lc3x_pkg::S_DECODE;
              end
            end
          endcase
        end
      end
      lc3x_pkg::S_MRD: begin
        cmd.emit      = 1'b1;
        cmd.emit_rd   = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = lc3x_pkg::S_IDLE;
      end
      lc3x_pkg::S_DECODE: begin
        cmd.load_ir = 1'b1;
        state_nxt   = lc3x_pkg::S_OPA;
      end
      lc3x_pkg::S_OPA: begin
        cmd.load_a = 1'b1;
        state_nxt  = lc3x_pkg::S_EXEC;
      end
      lc3x_pkg::S_EXEC: begin
        if (!stat.legal) begin
          done_st_nxt = lc3x_pkg::ST_ILLEGAL;
          state_nxt   = lc3x_pkg::S_DONE;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = lc3x_pkg::S_DONE;
          case (stat.opc) inside
            lc3x_pkg::OPC_LD, lc3x_pkg::OPC_LDR, lc3x_pkg::OPC_LDI,
            lc3x_pkg::OPC_ST, lc3x_pkg::OPC_STR, lc3x_pkg::OPC_STI:
              state_nxt = lc3x_pkg::S_MEMA;
            lc3x_pkg::OPC_TRAP: begin
              if (stat.vec == lc3x_pkg::TRAP_OUT) begin
                done_ch_nxt = lc3x_pkg::CH_A;
              end else if (stat.vec == lc3x_pkg::TRAP_PUTS) begin
                cmd.mem_sel    = lc3x_pkg::MA_A;
                cmd.puts_start = 1'b1;
                state_nxt      = lc3x_pkg::S_PUTS;
              end
            end
            default: ;
          endcase
        end
      end
      lc3x_pkg::S_MEMA: begin
        cmd.mem_sel = lc3x_pkg::MA_EA;
        if (stat.opc == lc3x_pkg::OPC_ST || stat.opc == lc3x_pkg::OPC_STR) begin
          cmd.mem_we = 1'b1;
          cmd.wd_sel = lc3x_pkg::WD_B;
          state_nxt  = lc3x_pkg::S_DONE;
        end else begin
          state_nxt  = lc3x_pkg::S_MEMB;
        end
      end
      lc3x_pkg::S_MEMB: begin
        state_nxt = lc3x_pkg::S_DONE;
        if (stat.opc == lc3x_pkg::OPC_LDI) begin
          cmd.mem_sel = lc3x_pkg::MA_RDATA;
          state_nxt   = lc3x_pkg::S_MEMC;
        end else if (stat.opc == lc3x_pkg::OPC_STI) begin
          cmd.mem_sel = lc3x_pkg::MA_RDATA;
          cmd.mem_we  = 1'b1;
          cmd.wd_sel  = lc3x_pkg::WD_B;
        end else begin
          cmd.load_wb = 1'b1;
        end
      end
      lc3x_pkg::S_MEMC: begin
        cmd.load_wb = 1'b1;
        state_nxt   = lc3x_pkg::S_DONE;
      end
      lc3x_pkg::S_PUTS: begin
        if (stat.word_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_char = stat.cnt_zero ? lc3x_pkg::CH_NONE : lc3x_pkg::CH_HELD;
          state_nxt     = lc3x_pkg::S_IDLE;
        end else begin
          cmd.mem_sel   = lc3x_pkg::MA_PTRN;
          cmd.puts_step = 1'b1;
          cmd.emit      = !stat.cnt_zero;
          cmd.emit_char = lc3x_pkg::CH_HELD;
          if (stat.cnt_full) state_nxt = lc3x_pkg::S_PEND;
        end
      end
      lc3x_pkg::S_PEND: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_char = lc3x_pkg::CH_HELD;
        state_nxt     = lc3x_pkg::S_IDLE;
      end
      lc3x_pkg::S_DONE: begin
        cmd.emit        = 1'b1;
        cmd.emit_last   = 1'b1;
        cmd.emit_status = done_st_r;
        cmd.emit_char   = done_ch_r;
        state_nxt       = lc3x_pkg::S_IDLE;
      end
      default: state_nxt = lc3x_pkg::S_CLEAR;
    endcase
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lc3x_pkg::S_CLEAR |-> !cmd.emit)
    else $error("result emitted during memory clear");

  a_step_fetches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lc3x_pkg::S_IDLE && start && op == lc3x_pkg::OP_EXEC && !stat.halted)
    |=> state_r == lc3x_pkg::S_DECODE)
    else $error("step did not start a fetch");

  a_pend_from_puts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lc3x_pkg::S_PEND |-> $past(state_r) == lc3x_pkg::S_PUTS)
    else $error("string tail without string walk");

  a_puts_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lc3x_pkg::S_PUTS |-> !cmd.mem_we)
    else $error("memory write during string walk");

endmodule

// ===== sv/lc3x_dp.sv =====
// Datapath: memory, register file, PC/PSR/halt/depth state, execution and result register.
module lc3x_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lc3x_pkg::in_beat_t  in_beat,
  input  lc3x_pkg::cmd_t      cmd,
  output lc3x_pkg::stat_t     stat,
  output logic                out_strobe,
  output lc3x_pkg::out_beat_t out_beat
);

  localparam int AB = lc3x_pkg::ADDR_BITS;
  localparam int CW = lc3x_pkg::CNT_W;

  logic [15:0] pc_r, ir_r, a_r, b_r, ea_r, ptr_r;
  logic [2:0]  cc_r;
  logic        halt_r;
  logic [15:0] depth_r;
  logic [7:0]  key_r, hc_r;
  logic [CW-1:0] cnt_r;
  logic [AB-1:0] clr_r;
  logic [7:0]  rvalid_r;
  logic        vq_r;
  logic        out_strobe_r;
  lc3x_pkg::out_beat_t out_r;

  logic [15:0] mem_rdata, mem_addr16, mem_wdata;
  logic [15:0] rf_rdata, rf_wdata, reg_val;
  logic [2:0]  rf_raddr, rf_waddr;
  logic        rf_we;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    else if (v == 16'd0) return 3'b010;
    else return 3'b001;
  endfunction

  function automatic logic is_legal(input logic [15:0] ir);
    logic ok;
    ok = 1'b1;
    case (ir[15:12])
      lc3x_pkg::OPC_BR:  ok = (ir[11:9] != 3'd0);
      lc3x_pkg::OPC_ADD,
      lc3x_pkg::OPC_AND: ok = ir[5] || (ir[4:3] == 2'd0);
      lc3x_pkg::OPC_JSR,
      lc3x_pkg::OPC_JMP: ok = ir[11] || (ir[11:9] == 3'd0 && ir[5:0] == 6'd0);
      lc3x_pkg::OPC_RTI: ok = (ir[11:0] == 12'd0);
      lc3x_pkg::OPC_NOT: ok = (ir[5:0] == 6'h3F);
      lc3x_pkg::OPC_RSV: ok = 1'b0;
      lc3x_pkg::OPC_TRAP:
        ok = (ir[11:8] == 4'd0) && (ir[7:0] >= lc3x_pkg::TRAP_GETC)
             && (ir[7:0] <= lc3x_pkg::TRAP_HALT);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  // main memory address and write data
  always_comb begin
    case (cmd.mem_sel)
      lc3x_pkg::MA_IN:    mem_addr16 = in_beat.address;
      lc3x_pkg::MA_PC:    mem_addr16 = pc_r;
      lc3x_pkg::MA_EA:    mem_addr16 = ea_r;
      lc3x_pkg::MA_RDATA: mem_addr16 = mem_rdata;
      lc3x_pkg::MA_A:     mem_addr16 = a_r;
      lc3x_pkg::MA_PTRN:  mem_addr16 = ptr_r + 16'd1;
      lc3x_pkg::MA_CLR:   mem_addr16 = 16'(clr_r);
      default:            mem_addr16 = pc_r;
    endcase
    case (cmd.wd_sel)
      lc3x_pkg::WD_IN: mem_wdata = in_beat.data;
      lc3x_pkg::WD_B:  mem_wdata = b_r;
      default:         mem_wdata = 16'd0;
    endcase
  end

  lc3x_ram #(.WIDTH(16), .DEPTH(lc3x_pkg::MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (mem_addr16[AB-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_addr16[AB-1:0]),
    .rdata (mem_rdata)
  );

  // instruction fields
  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic [15:0] npc, off9, off6, off11, imm5, op2, ea_nxt;
  assign opc   = ir_r[15:12];
  assign dr    = ir_r[11:9];
  assign sr1   = ir_r[8:6];
  assign npc   = pc_r + 16'd1;
  assign off9  = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6  = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign imm5  = {{11{ir_r[4]}}, ir_r[4:0]};
  assign op2   = ir_r[5] ? imm5 : reg_val;
  assign ea_nxt = (opc == lc3x_pkg::OPC_LDR || opc == lc3x_pkg::OPC_STR)
                  ? a_r + off6 : npc + off9;

  // register file read: first operand from the fetched word, second from IR
  always_comb begin
    if (cmd.load_ir) begin
      rf_raddr = (mem_rdata[15:12] == lc3x_pkg::OPC_TRAP) ? 3'd0 : mem_rdata[8:6];
    end else begin
      rf_raddr = (opc == lc3x_pkg::OPC_ADD || opc == lc3x_pkg::OPC_AND) ? ir_r[2:0] : dr;
    end
  end
  assign reg_val = vq_r ? rf_rdata : 16'd0;

  // execute results
  logic        ex_we, ex_cc;
  logic [2:0]  ex_waddr;
  logic [15:0] ex_wdata, ex_pc, ex_depth;
  logic        ex_halt;
  always_comb begin
    ex_we    = 1'b0;
    ex_cc    = 1'b0;
    ex_waddr = dr;
    ex_wdata = 16'd0;
    ex_pc    = npc;
    ex_depth = depth_r;
    ex_halt  = 1'b0;
    case (opc)
      lc3x_pkg::OPC_BR:
        if ((dr & cc_r) != 3'd0) ex_pc = npc + off9;
      lc3x_pkg::OPC_ADD: begin
        ex_we = 1'b1; ex_cc = 1'b1; ex_wdata = a_r + op2;
      end
      lc3x_pkg::OPC_AND: begin
        ex_we = 1'b1; ex_cc = 1'b1; ex_wdata = a_r & op2;
      end
      lc3x_pkg::OPC_NOT: begin
        ex_we = 1'b1; ex_cc = 1'b1; ex_wdata = ~a_r;
      end
      lc3x_pkg::OPC_LEA: begin
        ex_we = 1'b1; ex_cc = 1'b1; ex_wdata = npc + off9;
      end
      lc3x_pkg::OPC_JSR: begin
        ex_we    = 1'b1;
        ex_waddr = 3'd7;
        ex_wdata = npc;
        ex_pc    = ir_r[11] ? npc + off11 : a_r;
        ex_depth = depth_r + 16'd1;
      end
      lc3x_pkg::OPC_JMP: begin
        ex_pc = a_r;
        if (sr1 == 3'd7) ex_depth = depth_r - 16'd1;
      end
      lc3x_pkg::OPC_TRAP: begin
        if (ir_r[7:0] == lc3x_pkg::TRAP_GETC) begin
          ex_we    = 1'b1;
          ex_waddr = 3'd0;
          ex_wdata = {8'd0, key_r};
        end
        if (ir_r[7:0] == lc3x_pkg::TRAP_HALT) ex_halt = 1'b1;
      end
      default: ;
    endcase
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = dr;
    rf_wdata = mem_rdata;
    if (cmd.host_wr) begin
      rf_we    = !in_beat.reg_index[3];
      rf_waddr = in_beat.reg_index[2:0];
      rf_wdata = in_beat.data;
    end else if (cmd.exec) begin
      rf_we    = ex_we;
      rf_waddr = ex_waddr;
      rf_wdata = ex_wdata;
    end else if (cmd.load_wb) begin
      rf_we = 1'b1;
    end
  end

  lc3x_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= 16'd0;
      cc_r         <= lc3x_pkg::PSR_INIT[2:0];
      halt_r       <= 1'b0;
      depth_r      <= 16'd0;
      rvalid_r     <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.clr_step) clr_r <= clr_r + AB'(1);
      if (rf_we) rvalid_r[rf_waddr] <= 1'b1;
      if (cmd.host_wr) begin
        if (in_beat.reg_index == lc3x_pkg::REG_PC) begin
          pc_r   <= in_beat.data;
          halt_r <= 1'b0;
        end else if (in_beat.reg_index == lc3x_pkg::REG_PSR) begin
          cc_r <= in_beat.data[2:0];
        end
      end
      if (cmd.exec) begin
        pc_r    <= ex_pc;
        depth_r <= ex_depth;
        if (ex_cc) cc_r <= cc_of(ex_wdata);
        if (ex_halt) halt_r <= 1'b1;
      end
      if (cmd.load_wb) cc_r <= cc_of(mem_rdata);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vq_r <= rvalid_r[rf_raddr] && !(rf_we && rf_waddr == rf_raddr);
    if (cmd.latch_key) key_r <= in_beat.key_char;
    if (cmd.load_ir) ir_r <= mem_rdata;
    if (cmd.load_a) a_r <= reg_val;
    if (cmd.exec) begin
      b_r  <= reg_val;
      ea_r <= ea_nxt;
    end
    if (cmd.puts_start) begin
      ptr_r <= a_r;
      cnt_r <= '0;
    end
    if (cmd.puts_step) begin
      ptr_r <= ptr_r + 16'd1;
      cnt_r <= cnt_r + CW'(1);
      hc_r  <= mem_rdata[7:0];
    end
    if (cmd.emit) begin
      out_r.status     <= cmd.emit_status;
      out_r.pc         <= pc_r;
      out_r.read_data  <= cmd.emit_rd ? mem_rdata : 16'd0;
      out_r.cond_codes <= cc_r;
      out_r.char_valid <= (cmd.emit_char != lc3x_pkg::CH_NONE);
      case (cmd.emit_char)
        lc3x_pkg::CH_A:    out_r.out_char <= a_r[7:0];
        lc3x_pkg::CH_HELD: out_r.out_char <= hc_r;
        default:           out_r.out_char <= 8'd0;
      endcase
      out_r.call_depth <= depth_r;
      out_r.last       <= cmd.emit_last;
    end
  end

  assign stat.halted    = halt_r;
  assign stat.legal     = is_legal(ir_r);
  assign stat.opc       = opc;
  assign stat.vec       = ir_r[7:0];
  assign stat.word_zero = (mem_rdata == 16'd0);
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.cnt_full  = (cnt_r == CW'(lc3x_pkg::PUTS_LIMIT - 1));
  assign stat.clr_done  = &clr_r;

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_r;

endmodule

// ===== sv/lc3_instruction_executor.sv =====
// Top level: LC-3 instruction executor with host memory and register access.
//
// Usage:
// - Input: an item (in_beat) is taken on a rising edge with start high and
//   busy low. op selects execute step, memory write, memory read or
//   register write (index 8 loads PC and clears halt, index 9 loads PSR).
// - Output: each result beat sits on out_beat for exactly one cycle with
//   out_strobe high; out_beat.last marks the final beat of an item. The
//   receiver cannot stall, so every beat must be taken when it shows.
// - Sequence: host ops and a halted step go straight to their result beat;
//   other steps pass decode, operand read and execute phases, and loads and
//   stores add memory phases (LDI/STI take a second memory access). PUTS gives
//   one character beat per cycle, up to PUTS_LIMIT.
// - Throughput: one item at a time; busy is high from acceptance until the
//   last beat has been produced. The single-port main memory, with its
//   registered read, and the register file read port set the phase count.
// - Reset: rst_n (synchronous, active low) clears PC, halt, call depth,
//   condition codes and register valid bits, then a clearing pass writes
//   zero to all 2^ADDR_BITS memory words with busy high.
module lc3_instruction_executor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lc3x_pkg::in_beat_t  in_beat,
  output logic                out_strobe,
  output lc3x_pkg::out_beat_t out_beat
);

  lc3x_pkg::cmd_t  cmd;
  lc3x_pkg::stat_t stat;

  // sequencer: owns the phase of each item
  lc3x_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_beat.op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: memories, architectural state and result register
  lc3x_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beat    (in_beat),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

endmodule

// ===== dv/lc3_executor_checker.sv =====
// Result checker for the LC-3 instruction executor: predicts and compares each result beat.
`timescale 1ns / 100ps
module lc3_executor_checker
  import lc3x_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_beat,
  input  logic      out_strobe,
  input  out_beat_t out_beat,
  output int        fail_count,
  output int        pending_beats
);

  logic [15:0] cpu_mem [0:MEM_DEPTH-1];
  logic [15:0] cpu_regs [0:7];
  logic [15:0] cpu_pc;
  logic [15:0] cpu_psr;
  logic        cpu_halted;
  logic [15:0] cpu_depth;
  out_beat_t   expected_beats[$];
  int          beats_seen;

  function automatic logic [15:0] sign_ext(logic [15:0] v, int bits);
    logic [15:0] m;
    m = (16'd1 << bits) - 16'd1;
    v &= m;
    if (v[bits-1]) v |= ~m;
    return v;
  endfunction

  function automatic logic instr_ok(logic [15:0] ir);
    logic [3:0] opc;
    opc = ir[15:12];
    case (opc)
      OPC_BR:           return ir[11:9] != 3'd0;
      OPC_ADD, OPC_AND: return ir[5] || ir[4:3] == 2'd0;
      OPC_JSR, OPC_JMP: return ir[11] || (ir[11:9] == 3'd0 && ir[5:0] == 6'd0);
      OPC_RTI:          return ir[11:0] == 12'd0;
      OPC_NOT:          return ir[5:0] == 6'h3F;
      OPC_RSV:          return 1'b0;
      OPC_TRAP:         return ir[11:8] == 4'd0 && ir[7:0] >= TRAP_GETC
                               && ir[7:0] <= TRAP_HALT;
      default:          return 1'b1;
    endcase
  endfunction

  task automatic update_codes(logic [15:0] r);
    cpu_psr = PSR_INIT | (r[15] ? 16'd4 : (r == 16'd0 ? 16'd2 : 16'd1));
  endtask

  task automatic push_beat(logic [1:0] st, logic [15:0] rd, logic cv, logic [7:0] ch);
    out_beat_t b;
    b.status     = st;
    b.pc         = cpu_pc;
    b.read_data  = rd;
    b.cond_codes = cpu_psr[2:0];
    b.char_valid = cv;
    b.out_char   = cv ? ch : 8'd0;
    b.call_depth = cpu_depth;
    b.last       = 1'b0;
    expected_beats.push_back(b);
  endtask

  task automatic run_instruction(logic [7:0] key);
    logic [15:0] ir, npc, tgt, a;
    logic [2:0]  dr, sr1, sr2;
    int          n;
    n = 0;
    if (cpu_halted) begin
      push_beat(ST_HALT, 16'd0, 1'b0, 8'd0);
      return;
    end
    ir = cpu_mem[cpu_pc];
    if (!instr_ok(ir)) begin
      push_beat(ST_ILLEGAL, 16'd0, 1'b0, 8'd0);
      return;
    end
    npc = cpu_pc + 16'd1;
    cpu_pc = npc;
    dr = ir[11:9];
    sr1 = ir[8:6];
    sr2 = ir[2:0];
    case (ir[15:12])
      OPC_BR: if ((ir[11:9] & cpu_psr[2:0]) != 3'd0) cpu_pc = npc + sign_ext(ir, 9);
      OPC_ADD: begin
        cpu_regs[dr] = cpu_regs[sr1] + (ir[5] ? sign_ext(ir, 5) : cpu_regs[sr2]);
        update_codes(cpu_regs[dr]);
      end
      OPC_AND: begin
        cpu_regs[dr] = cpu_regs[sr1] & (ir[5] ? sign_ext(ir, 5) : cpu_regs[sr2]);
        update_codes(cpu_regs[dr]);
      end
      OPC_LD: begin
        cpu_regs[dr] = cpu_mem[npc + sign_ext(ir, 9)];
        update_codes(cpu_regs[dr]);
      end
      OPC_ST: cpu_mem[npc + sign_ext(ir, 9)] = cpu_regs[dr];
      OPC_JSR: begin
        // target taken before R7 is overwritten
        tgt = ir[11] ? npc + sign_ext(ir, 11) : cpu_regs[sr1];
        cpu_regs[7] = npc;
        cpu_pc = tgt;
        cpu_depth = cpu_depth + 16'd1;
      end
      OPC_LDR: begin
        cpu_regs[dr] = cpu_mem[cpu_regs[sr1] + sign_ext(ir, 6)];
        update_codes(cpu_regs[dr]);
      end
      OPC_STR: cpu_mem[cpu_regs[sr1] + sign_ext(ir, 6)] = cpu_regs[dr];
      OPC_NOT: begin
        cpu_regs[dr] = ~cpu_regs[sr1];
        update_codes(cpu_regs[dr]);
      end
      OPC_LDI: begin
        cpu_regs[dr] = cpu_mem[cpu_mem[npc + sign_ext(ir, 9)]];
        update_codes(cpu_regs[dr]);
      end
      OPC_STI: cpu_mem[cpu_mem[npc + sign_ext(ir, 9)]] = cpu_regs[dr];
      OPC_JMP: begin
        cpu_pc = cpu_regs[sr1];
        if (sr1 == 3'd7) cpu_depth = cpu_depth - 16'd1;
      end
      OPC_LEA: begin
        cpu_regs[dr] = npc + sign_ext(ir, 9);
        update_codes(cpu_regs[dr]);
      end
      OPC_TRAP: begin
        case (ir[7:0])
          TRAP_GETC: cpu_regs[0] = {8'd0, key};
          TRAP_OUT: begin
            push_beat(ST_OK, 16'd0, 1'b1, cpu_regs[0][7:0]);
            n++;
          end
          TRAP_PUTS: begin
            a = cpu_regs[0];
            while (n < PUTS_LIMIT && cpu_mem[a] != 16'd0) begin
              push_beat(ST_OK, 16'd0, 1'b1, cpu_mem[a][7:0]);
              n++;
              a = a + 16'd1;
            end
          end
          TRAP_HALT: cpu_halted = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (n == 0) push_beat(ST_OK, 16'd0, 1'b0, 8'd0);
  endtask

  task automatic predict_item(in_beat_t it);
    logic [15:0] rd;
    rd = 16'd0;
    if (it.op == OP_EXEC) begin
      run_instruction(it.key_char);
    end else begin
      if (it.op == OP_MWR) cpu_mem[it.address] = it.data;
      else if (it.op == OP_MRD) rd = cpu_mem[it.address];
      else if (it.reg_index < 4'd8) cpu_regs[it.reg_index[2:0]] = it.data;
      else if (it.reg_index == REG_PC) begin
        cpu_pc = it.data;
        cpu_halted = 1'b0;
      end else if (it.reg_index == REG_PSR) cpu_psr = it.data;
      push_beat(ST_OK, rd, 1'b0, 8'd0);
    end
    expected_beats[$].last = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) cpu_mem[i] = 16'd0;
    for (int i = 0; i < 8; i++) cpu_regs[i] = 16'd0;
    cpu_pc = 16'd0;
    cpu_psr = PSR_INIT;
    cpu_halted = 1'b0;
    cpu_depth = 16'd0;
    fail_count = 0;
    pending_beats = 0;
    beats_seen = 0;
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      // compare before predicting: a beat cannot belong to an item taken this edge
      if (out_strobe) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat %p", $realtime, out_beat);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (want !== out_beat) begin
            $display("%0t: beat mismatch expected %p actual %p", $realtime, want, out_beat);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_item(in_beat);
    end
    pending_beats = expected_beats.size();
  end

endmodule

// ===== dv/lc3_instruction_executor_tb.sv =====
// Testbench top: drives host and execute items into the LC-3 executor and gives the verdict.
`timescale 1ns / 100ps
module lc3_instruction_executor_tb;
  import lc3x_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_beat;
  logic      out_strobe;
  out_beat_t out_beat;
  int        fail_count;
  int        pending_beats;
  int        idle_cycles;
  int        items_sent;
  int        steps_sent;
  bit        quiet_stretch;
  bit        timed_out;

  // the reset clearing pass writes every memory word with no beats; leave generous margin
  localparam int WATCHDOG_LIMIT = 200000;

  lc3_instruction_executor u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_strobe(out_strobe), .out_beat(out_beat)
  );

  lc3_executor_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_strobe(out_strobe), .out_beat(out_beat),
    .fail_count(fail_count), .pending_beats(pending_beats)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog: cycles with no beat accepted in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // one beat into the block; start held until it is taken at a rising edge
  task automatic send_item(host_op_t op, logic [15:0] addr, logic [15:0] data,
                           logic [3:0] ri, logic [7:0] key);
    while (!quiet_stretch && $urandom_range(99) < 19) @(negedge clk);
    in_beat.op        = op;
    in_beat.address   = addr;
    in_beat.data      = data;
    in_beat.reg_index = ri;
    in_beat.key_char  = key;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    items_sent++;
    if (op == OP_EXEC) steps_sent++;
  endtask

  task automatic poke(logic [15:0] addr, logic [15:0] data);
    send_item(OP_MWR, addr, data, 4'd0, 8'd0);
  endtask

  task automatic set_reg(logic [3:0] ri, logic [15:0] data);
    send_item(OP_RWR, 16'd0, data, ri, 8'd0);
  endtask

  // load instruction at PC, point PC there (clears halt), execute
  task automatic run_at(logic [15:0] pc, logic [15:0] ir, logic [7:0] key);
    poke(pc, ir);
    set_reg(REG_PC, pc);
    send_item(OP_EXEC, 16'd0, 16'd0, 4'd0, key);
  endtask

  // random legal-leaning instruction word
  function automatic logic [15:0] random_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    case ($urandom_range(9))
      0: ir[15:12] = OPC_TRAP;
      1: ir = {OPC_TRAP, 4'd0, 8'(TRAP_GETC + $urandom_range(5))};
      2: ir = {OPC_TRAP, 4'd0, 8'(TRAP_GETC + $urandom_range(5))};
      3: begin ir[15:12] = OPC_ADD; ir[4:3] = 2'd0; end
      4: begin ir[15:12] = OPC_NOT; ir[5:0] = 6'h3F; end
      5: begin ir[15:12] = OPC_JMP; ir[11:9] = 3'd0; ir[5:0] = 6'd0; end
      6: ir = {OPC_RTI, 12'd0};
      default: ;
    endcase
    return ir;
  endfunction

  initial begin
    logic [15:0] base;
    int          len;
    rst_n = 1'b0;
    start = 1'b0;
    in_beat = '0;
    idle_cycles = 0;
    items_sent = 0;
    steps_sent = 0;
    quiet_stretch = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: host ops at field extremes
    poke(16'hFFFF, 16'hFFFF);
    send_item(OP_MRD, 16'hFFFF, 16'd0, 4'd0, 8'd0);
    send_item(OP_MRD, 16'h0000, 16'd0, 4'd0, 8'd0);
    set_reg(4'd15, 16'hFFFF);        // ignored index
    set_reg(REG_PSR, 16'h8004);
    set_reg(4'd7, 16'h8000);
    // JSRR through R7, then RET
    run_at(16'h1000, {OPC_JSR, 3'd0, 3'd7, 6'd0}, 8'd0);
    run_at(16'h8000, {OPC_JMP, 3'd0, 3'd7, 6'd0}, 8'd0);
    run_at(16'hFFFF, {OPC_BR, 3'd0, 9'h001}, 8'd0);   // nzp zero: illegal
    run_at(16'h0010, {OPC_RSV, 12'hFFF}, 8'd0);       // reserved opcode
    run_at(16'h0011, {OPC_TRAP, 4'd0, 8'h26}, 8'd0);  // bad vector
    run_at(16'h0012, {OPC_RTI, 12'd0}, 8'd0);
    run_at(16'h0013, {OPC_TRAP, 4'd0, TRAP_GETC}, 8'hFF);
    run_at(16'h0014, {OPC_TRAP, 4'd0, TRAP_OUT}, 8'd0);
    // empty string, then a string longer than the cap
    set_reg(4'd0, 16'h2000);
    run_at(16'h0015, {OPC_TRAP, 4'd0, TRAP_PUTS}, 8'd0);
    for (int i = 0; i < PUTS_LIMIT + 2; i++) poke(16'h2000 + 16'(i), 16'h0141 + 16'(i));
    run_at(16'h0016, {OPC_TRAP, 4'd0, TRAP_PUTS}, 8'd0);
    run_at(16'h0017, {OPC_TRAP, 4'd0, TRAP_HALT}, 8'd0);
    send_item(OP_EXEC, 16'd0, 16'd0, 4'd0, 8'd0);    // halted step
    send_item(OP_MRD, 16'h0017, 16'd0, 4'd0, 8'd0); // host ops pass while halted

    // random: mostly short programs of random instructions, some host noise
    while (items_sent < 275) begin
      quiet_stretch = (items_sent >= 150 && items_sent < 200);
      case ($urandom_range(9))
        0: send_item(host_op_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
                     4'($urandom), 8'($urandom));
        1: set_reg(4'($urandom_range(9)), 16'($urandom));
        2: begin
          // short string for PUTS
          base = 16'($urandom);
          len = $urandom_range(4);
          for (int i = 0; i < len; i++) poke(base + 16'(i), 16'($urandom_range(1, 65535)));
          poke(base + 16'(len), 16'd0);
          set_reg(4'd0, base);
          run_at(16'($urandom), {OPC_TRAP, 4'd0, TRAP_PUTS}, 8'($urandom));
        end
        default: begin
          base = 16'($urandom);
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) poke(base + 16'(i), random_instr());
          set_reg(REG_PC, base);
          for (int i = 0; i < len; i++)
            send_item(OP_EXEC, 16'd0, 16'd0, 4'd0, 8'($urandom));
        end
      endcase
    end

    while (pending_beats != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d items, %0d of them execute steps, covering all opcodes,", items_sent,
             steps_sent);
    $display("trap vectors, illegal forms, halt and capped string output.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
